>>> src/asps_pkg.sv
`timescale 1ns / 1ps
// asps_pkg: shared sizes, types and codes of the aging priority scheduler
// no dependencies; imported by every module of the block

package asps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int PRIO_W    = 6;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef struct packed {
    prio_t stat;
    prio_t dyn;
  } prio_ent_t;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_SETP   = 3'd2;
  localparam logic [2:0] MODE_GETP   = 3'd3;
  localparam logic [2:0] MODE_SCHED  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPRIO  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTREADY = 2'd3;

  localparam prio_t PRIO_FLOOR = -6'sd19;
  localparam prio_t PRIO_BELOW = -6'sd20;
  localparam prio_t PRIO_ABOVE = 6'sd20;

endpackage

>>> src/aging_priority_scheduler.sv
`timescale 1ns / 1ps
// aging_priority_scheduler: top level sequencer of the task scheduler with priority aging
// uses asps_pkg, asps_prio_ram and asps_order_ram
//
//   channel | ports                                                   | dir
//   in      | in_valid in_ready in_mode in_task_slot in_use_current   | in
//           | in_new_priority                                         |
//   out     | out_valid out_ready out_chosen_task out_chosen_valid    | out
//           | out_read_priority out_status                            |
//
// one transaction at a time; add, set_priority and unused modes go from exec straight to the result,
// get_priority adds a priority read, remove walks the ready list memory once and schedule walks it
// twice when the list is not empty (one entry read per cycle)
// reset clears the list, the current task and the priority valid bits; no clearing pass
// a result not yet taken holds the next transaction at its last step

module aging_priority_scheduler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_mode,
  input  logic [3:0]           in_task_slot,
  input  logic                 in_use_current,
  input  logic signed [5:0]    in_new_priority,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_chosen_task,
  output logic                 out_chosen_valid,
  output logic signed [5:0]    out_read_priority,
  output logic [1:0]           out_status
);
  import asps_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_GET_RD = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [MAX_TASKS-1:0] ready_r, ready_nxt;
  cnt_t                 cnt_r, cnt_nxt;
  slot_t                cur_r, cur_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic                 s2_vld_r, s2_vld_nxt;

  logic [2:0]           mode_r, mode_nxt;
  slot_t                tgt_r, tgt_nxt;
  logic                 in_rng_r, in_rng_nxt;
  prio_t                prio_r, prio_nxt;
  logic [3:0]           res_chosen_r, res_chosen_nxt;
  logic                 res_valid_r, res_valid_nxt;
  prio_t                res_rd_r, res_rd_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  cnt_t                 ord_idx_r, ord_idx_nxt;
  slot_t                s1_pos_r, s1_pos_nxt;
  slot_t                s2_slot_r, s2_slot_nxt;
  logic                 found_r, found_nxt;
  logic                 pass_r, pass_nxt;
  logic                 have_best_r, have_best_nxt;
  slot_t                best_slot_r, best_slot_nxt;
  prio_t                best_dyn_r, best_dyn_nxt;
  logic [3:0]           out_chosen_r;
  logic                 out_cvalid_r;
  prio_t                out_rd_r;
  logic [1:0]           out_status_r;
  logic                 out_load;

  logic                 ord_we;
  slot_t                ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic                 pr_we;
  slot_t                pr_waddr, pr_raddr;
  prio_ent_t            pr_wdata, pr_rdata;
  logic                 issue;
  prio_t                dyn;

  asps_order_ram u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  asps_prio_ram u_prio_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign issue    = (ord_idx_r < cnt_r);
  assign dyn      = pr_rdata.dyn;

  always_comb begin
    state_nxt      = state_r;
    ready_nxt      = ready_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = out_valid_r;
    s1_vld_nxt     = s1_vld_r;
    s2_vld_nxt     = s2_vld_r;
    mode_nxt       = mode_r;
    tgt_nxt        = tgt_r;
    in_rng_nxt     = in_rng_r;
    prio_nxt       = prio_r;
    res_chosen_nxt = res_chosen_r;
    res_valid_nxt  = res_valid_r;
    res_rd_nxt     = res_rd_r;
    res_status_nxt = res_status_r;
    ord_idx_nxt    = ord_idx_r;
    s1_pos_nxt     = s1_pos_r;
    s2_slot_nxt    = s2_slot_r;
    found_nxt      = found_r;
    pass_nxt       = pass_r;
    have_best_nxt  = have_best_r;
    best_slot_nxt  = best_slot_r;
    best_dyn_nxt   = best_dyn_r;
    out_load       = 1'b0;
    ord_we         = 1'b0;
    ord_waddr      = s1_pos_r - 1'b1;
    ord_wdata      = ord_rdata;
    ord_raddr      = ord_idx_r[SLOT_W-1:0];
    pr_we          = 1'b0;
    pr_waddr       = tgt_r;
    pr_wdata       = '0;
    pr_raddr       = tgt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt       = in_mode;
          in_rng_nxt     = in_use_current || (int'(in_task_slot) < MAX_TASKS);
          tgt_nxt        = in_use_current ? cur_r : slot_t'(in_task_slot);
          prio_nxt       = in_new_priority;
          res_chosen_nxt = '0;
          res_valid_nxt  = 1'b0;
          res_rd_nxt     = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (mode_r)
          MODE_ADD: begin
            if (!in_rng_r) begin
              res_status_nxt = ST_NOTREADY;
            end else if (cnt_r == cnt_t'(MAX_TASKS) || ready_r[tgt_r]) begin
              res_status_nxt = ST_FULL;
            end else begin
              ord_we           = 1'b1;
              ord_waddr        = cnt_r[SLOT_W-1:0];
              ord_wdata        = tgt_r;
              pr_we            = 1'b1;
              pr_wdata         = '0;
              ready_nxt[tgt_r] = 1'b1;
              cnt_nxt          = cnt_r + 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (!in_rng_r || !ready_r[tgt_r]) begin
              res_status_nxt = ST_NOTREADY;
            end else begin
              ord_idx_nxt = '0;
              found_nxt   = 1'b0;
              state_nxt   = S_WALK;
            end
          end
          MODE_SETP: begin
            if (!in_rng_r) begin
              res_status_nxt = ST_NOTREADY;
            end else if (prio_r > PRIO_BELOW && prio_r < PRIO_ABOVE) begin
              pr_we         = 1'b1;
              pr_wdata.stat = prio_r;
              pr_wdata.dyn  = prio_r;
            end else begin
              res_status_nxt = ST_BADPRIO;
            end
          end
          MODE_GETP: begin
            if (!in_rng_r) begin
              res_status_nxt = ST_NOTREADY;
            end else begin
              state_nxt = S_GET_RD;
            end
          end
          MODE_SCHED: begin
            if (cnt_r != '0) begin
              ord_idx_nxt   = '0;
              pass_nxt      = 1'b0;
              have_best_nxt = 1'b0;
              state_nxt     = S_WALK;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_GET_RD: begin
        res_rd_nxt = pr_rdata.stat;
        state_nxt  = S_FIN;
      end
      S_WALK: begin
        // stage 0 reads the list, stage 1 reads the slot priority, stage 2 uses it
        s1_vld_nxt = issue;
        s2_vld_nxt = 1'b0;
        if (issue) begin
          ord_idx_nxt = ord_idx_r + 1'b1;
          s1_pos_nxt  = ord_idx_r[SLOT_W-1:0];
        end
        if (s1_vld_r) begin
          if (mode_r == MODE_REMOVE) begin
            if (found_r) begin
              ord_we = 1'b1;
            end
            if (ord_rdata == tgt_r) begin
              found_nxt = 1'b1;
            end
          end else begin
            pr_raddr    = ord_rdata;
            s2_vld_nxt  = 1'b1;
            s2_slot_nxt = ord_rdata;
          end
        end
        // list slots are distinct, so the write-back never hits the slot being read
        if (s2_vld_r) begin
          if (!pass_r) begin
            if (!have_best_r || dyn < best_dyn_r) begin
              have_best_nxt = 1'b1;
              best_slot_nxt = s2_slot_r;
              best_dyn_nxt  = dyn;
            end
          end else begin
            pr_we         = 1'b1;
            pr_waddr      = s2_slot_r;
            pr_wdata.stat = pr_rdata.stat;
            if (s2_slot_r == best_slot_r) begin
              pr_wdata.dyn = pr_rdata.stat;
            end else if (dyn > PRIO_FLOOR) begin
              pr_wdata.dyn = prio_t'(dyn - 6'sd1);
            end else begin
              pr_wdata.dyn = dyn;
            end
          end
        end
        if (!issue && !s1_vld_r && !s2_vld_r) begin
          if (mode_r == MODE_REMOVE) begin
            cnt_nxt          = cnt_r - 1'b1;
            ready_nxt[tgt_r] = 1'b0;
            state_nxt        = S_FIN;
          end else if (!pass_r) begin
            pass_nxt    = 1'b1;
            ord_idx_nxt = '0;
          end else begin
            cur_nxt        = best_slot_r;
            res_chosen_nxt = 4'(best_slot_r);
            res_valid_nxt  = 1'b1;
            state_nxt      = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= '0;
      cnt_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    tgt_r        <= tgt_nxt;
    in_rng_r     <= in_rng_nxt;
    prio_r       <= prio_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_valid_r  <= res_valid_nxt;
    res_rd_r     <= res_rd_nxt;
    res_status_r <= res_status_nxt;
    ord_idx_r    <= ord_idx_nxt;
    s1_pos_r     <= s1_pos_nxt;
    s2_slot_r    <= s2_slot_nxt;
    found_r      <= found_nxt;
    pass_r       <= pass_nxt;
    have_best_r  <= have_best_nxt;
    best_slot_r  <= best_slot_nxt;
    best_dyn_r   <= best_dyn_nxt;
    if (out_load) begin
      out_chosen_r <= res_chosen_r;
      out_cvalid_r <= res_valid_r;
      out_rd_r     <= res_rd_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_task   = out_chosen_r;
  assign out_chosen_valid  = out_cvalid_r;
  assign out_read_priority = out_rd_r;
  assign out_status        = out_status_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_TASKS)
    else $error("ready count above capacity");

  a_cnt_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ready_r) == int'(cnt_r))
    else $error("ready flags disagree with ready count");

  a_s2_sched: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (state_r == S_WALK && mode_r == MODE_SCHED))
    else $error("priority stage active outside a schedule walk");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && mode_r == MODE_REMOVE && !issue && !s1_vld_r)
      |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("remove did not shorten the ready list");

endmodule

>>> src/asps_prio_ram.sv
`timescale 1ns / 1ps
// asps_prio_ram: per-slot static and dynamic priority memory, one write and one read port
// entries never written read as zero through reset-cleared valid bits; uses asps_pkg

module asps_prio_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  asps_pkg::slot_t     waddr,
  input  asps_pkg::prio_ent_t wdata,
  input  asps_pkg::slot_t     raddr,
  output asps_pkg::prio_ent_t rdata
);
  import asps_pkg::*;

  prio_ent_t              prio_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0]   vld_r;
  logic                   rd_vld_r;
  prio_ent_t              rd_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      prio_mem[waddr] <= wdata;
    end
    rd_q_r <= prio_mem[raddr];
  end

  assign rdata = rd_vld_r ? rd_q_r : '0;

endmodule

>>> src/asps_order_ram.sv
`timescale 1ns / 1ps
// asps_order_ram: ready list memory holding slot numbers in list order
// one write and one registered read port; uses asps_pkg

module asps_order_ram (
  input  logic            clk,
  input  logic            we,
  input  asps_pkg::slot_t waddr,
  input  asps_pkg::slot_t wdata,
  input  asps_pkg::slot_t raddr,
  output asps_pkg::slot_t rdata
);
  import asps_pkg::*;

  slot_t order_mem [MAX_TASKS];
  slot_t rd_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      order_mem[waddr] <= wdata;
    end
    rd_q_r <= order_mem[raddr];
  end

  assign rdata = rd_q_r;

endmodule
